/* design/fcs_pkg.sv */
// ----------------------------------------------------------------------------
// Flash command sequencer package
// Shared widths, command codes, mode and bus-cycle types, decode structs.
// ----------------------------------------------------------------------------
package fcs_pkg;

   // Default sizing of the array and the lock table
   localparam int ADDR_BITS_DEF   = 20;
   localparam int NUM_SECTORS_DEF = 23;

   // Fixed field widths
   localparam int ADDR_W     = 20;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 32;
   localparam int MODE_W     = 3;
   localparam int CMD_W      = 11;
   localparam int CSR_IDX_W  = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_MANUFACTURER = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEVICE       = 2'd1;

   localparam logic [BYTE_W-1:0] MANUFACTURER_RESET = 8'hBF;
   localparam logic [BYTE_W-1:0] DEVICE_RESET       = 8'h00;

   // Command addresses
   localparam logic [CMD_W-1:0]  CMD_ADDR_A   = 11'h555;
   localparam logic [CMD_W-1:0]  CMD_ADDR_B   = 11'h2AA;
   localparam logic [BYTE_W-1:0] CMD_CFI_LOW  = 8'h55;

   // Command bytes
   localparam logic [BYTE_W-1:0] BYTE_UNLOCK_A = 8'hAA;
   localparam logic [BYTE_W-1:0] BYTE_UNLOCK_B = 8'h55;
   localparam logic [BYTE_W-1:0] BYTE_CFI      = 8'h98;
   localparam logic [BYTE_W-1:0] BYTE_ERASE    = 8'h80;
   localparam logic [BYTE_W-1:0] BYTE_PID      = 8'h90;
   localparam logic [BYTE_W-1:0] BYTE_PROGRAM  = 8'hA0;
   localparam logic [BYTE_W-1:0] BYTE_EXIT     = 8'hF0;
   localparam logic [BYTE_W-1:0] BYTE_CHIP     = 8'h10;
   localparam logic [BYTE_W-1:0] BYTE_SECTOR   = 8'h30;
   localparam logic [BYTE_W-1:0] BYTE_LOCK     = 8'h60;

   localparam logic [BYTE_W-1:0] BYTE_ERASED   = 8'hFF;

   typedef enum logic [MODE_W-1:0] {
      MODE_READ  = 3'd0,
      MODE_CFI   = 3'd1,
      MODE_PID   = 3'd2,
      MODE_PROG  = 3'd3,
      MODE_ERASE = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      CYC_IDLE  = 3'd0,
      CYC_TWO   = 3'd1,
      CYC_THREE = 3'd2,
      CYC_FOUR  = 3'd3,
      CYC_FIVE  = 3'd4,
      CYC_SIX   = 3'd5
   } cycle_type;

   // Work that the datapath does for one item
   typedef enum logic [2:0] {
      OP_NONE,
      OP_READ_ARRAY,
      OP_READ_ID,
      OP_PROGRAM,
      OP_ERASE_CHIP,
      OP_ERASE_SECTOR,
      OP_LOCK
   } op_type;

   typedef struct packed {
      mode_type  mode;
      cycle_type cycle;
      mode_type  fb_mode;
      cycle_type fb_cycle;
   } cmd_state_type;

   typedef struct packed {
      op_type        op;
      cmd_state_type nxt;
   } dec_type;

   localparam cmd_state_type CST_RESET = '{
      mode: MODE_READ, cycle: CYC_IDLE, fb_mode: MODE_READ, fb_cycle: CYC_IDLE
   };

endpackage

/* design/fcs_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// One bus access per item: action, byte address and top write byte.
// ----------------------------------------------------------------------------
interface fcs_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [fcs_pkg::ADDR_W-1:0]   address;
   logic [fcs_pkg::BYTE_W-1:0]   write_byte;

   modport source (output valid, action, address, write_byte, input ready);
   modport sink   (input valid, action, address, write_byte, output ready);
endinterface

/* design/fcs_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// One result per access: read word, its valid flag and the mode afterwards.
// ----------------------------------------------------------------------------
interface fcs_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fcs_pkg::WORD_W-1:0]   read_data;
   logic                         read_valid;
   logic [fcs_pkg::MODE_W-1:0]   current_mode;

   modport source (output valid, read_data, read_valid, current_mode, input ready);
   modport sink   (input valid, read_data, read_valid, current_mode, output ready);
endinterface

/* design/fcs_csr_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data for the ID code registers.
// ----------------------------------------------------------------------------
interface fcs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fcs_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [fcs_pkg::BYTE_W-1:0]     write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

/* design/fcs_cmd_decode.sv */
// ----------------------------------------------------------------------------
// Command cycle decoder
// Walks the unlock sequences and picks the datapath operation for an item.
// ----------------------------------------------------------------------------
module fcs_cmd_decode (
   input  logic                         action,
   input  logic [fcs_pkg::CMD_W-1:0]    cmd,
   input  logic [fcs_pkg::BYTE_W-1:0]   wbyte,
   input  fcs_pkg::cmd_state_type       cur,
   output fcs_pkg::dec_type             dec
);
   import fcs_pkg::*;

   logic at_a;
   logic at_b;

   assign at_a = (cmd == CMD_ADDR_A);
   assign at_b = (cmd == CMD_ADDR_B);

   always_comb begin
      dec.op  = OP_NONE;
      dec.nxt = cur;
      if (!action) begin
         if (cur.mode == MODE_READ) begin
            dec.op = OP_READ_ARRAY;
         end else if (cur.mode == MODE_PID) begin
            dec.op = OP_READ_ID;
         end
      end else begin
         case (cur.mode)
            MODE_READ: begin
               case (cur.cycle)
                  CYC_IDLE: begin
                     if (cmd[7:0] == CMD_CFI_LOW && wbyte == BYTE_CFI) begin
                        dec.nxt = '{mode: MODE_CFI, cycle: CYC_IDLE,
                                    fb_mode: MODE_CFI, fb_cycle: CYC_IDLE};
                     end else if (at_a && wbyte == BYTE_UNLOCK_A) begin
                        dec.nxt.cycle = CYC_TWO;
                     end else begin
                        dec.nxt.mode  = cur.fb_mode;
                        dec.nxt.cycle = cur.fb_cycle;
                     end
                  end
                  CYC_TWO: begin
                     if (at_b && wbyte == BYTE_UNLOCK_B) begin
                        dec.nxt.cycle = CYC_THREE;
                     end else begin
                        dec.nxt.mode  = cur.fb_mode;
                        dec.nxt.cycle = cur.fb_cycle;
                     end
                  end
                  CYC_THREE: begin
                     if (at_a && wbyte == BYTE_ERASE) begin
                        dec.nxt.mode  = MODE_ERASE;
                        dec.nxt.cycle = CYC_FOUR;
                     end else if (at_a && wbyte == BYTE_PID) begin
                        dec.nxt = '{mode: MODE_PID, cycle: CYC_IDLE,
                                    fb_mode: MODE_PID, fb_cycle: CYC_IDLE};
                     end else if (at_a && wbyte == BYTE_PROGRAM) begin
                        dec.nxt.mode  = MODE_PROG;
                        dec.nxt.cycle = CYC_FOUR;
                     end else begin
                        dec.nxt.mode  = cur.fb_mode;
                        dec.nxt.cycle = cur.fb_cycle;
                     end
                  end
                  default: ;
               endcase
            end
            MODE_CFI, MODE_PID: begin
               if (wbyte == BYTE_EXIT) begin
                  dec.nxt = CST_RESET;
               end
            end
            MODE_PROG: begin
               dec.op  = OP_PROGRAM;
               dec.nxt = CST_RESET;
            end
            MODE_ERASE: begin
               case (cur.cycle)
                  CYC_FOUR: begin
                     if (at_a && wbyte == BYTE_UNLOCK_A) begin
                        dec.nxt.cycle = CYC_FIVE;
                     end else begin
                        dec.nxt.mode  = cur.fb_mode;
                        dec.nxt.cycle = cur.fb_cycle;
                     end
                  end
                  CYC_FIVE: begin
                     if (at_b && wbyte == BYTE_UNLOCK_B) begin
                        dec.nxt.cycle = CYC_SIX;
                     end else begin
                        dec.nxt.mode  = cur.fb_mode;
                        dec.nxt.cycle = cur.fb_cycle;
                     end
                  end
                  CYC_SIX: begin
                     // unknown byte: stay at this cycle
                     if (wbyte == BYTE_CHIP) begin
                        dec.op  = at_a ? OP_ERASE_CHIP : OP_NONE;
                        dec.nxt = CST_RESET;
                     end else if (wbyte == BYTE_SECTOR) begin
                        dec.op  = OP_ERASE_SECTOR;
                        dec.nxt = CST_RESET;
                     end else if (wbyte == BYTE_LOCK) begin
                        dec.op  = OP_LOCK;
                        dec.nxt = CST_RESET;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end
   end

endmodule

/* design/fcs_addr_unit.sv */
// ----------------------------------------------------------------------------
// Shared address unit
// One pointer with incrementer, used for byte reads, program and erase
// sweeps; derives the sector base, sector end and lock index of the pointer.
// ----------------------------------------------------------------------------
module fcs_addr_unit #(
   parameter int ADDR_BITS   = fcs_pkg::ADDR_BITS_DEF,
   parameter int NUM_SECTORS = fcs_pkg::NUM_SECTORS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [ADDR_BITS-1:0]            load_addr,
   input  logic                            advance,
   output logic [ADDR_BITS-1:0]            ptr,
   output logic [ADDR_BITS-1:0]            sector_base,
   output logic                            sector_last,
   output logic                            array_last,
   output logic [$clog2(NUM_SECTORS)-1:0]  lock_idx,
   output logic                            lock_in_range
);
   import fcs_pkg::*;

   localparam int LOCK_SPAN = 7 + (1 << (ADDR_BITS - 16));
   localparam int LW        = $clog2(LOCK_SPAN);
   localparam int SW        = $clog2(NUM_SECTORS);
   localparam int IW        = (LW > SW) ? LW : SW;

   logic [ADDR_BITS-1:0] ptr_ff;
   logic                 boot;
   logic [IW-1:0]        idx_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (load) begin
         ptr_ff <= load_addr;
      end else if (advance) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
   end

   // first 64 KB: eight 8 KB sectors, above it 64 KB sectors
   assign boot        = (ptr_ff[ADDR_BITS-1:16] == '0);
   assign sector_base = boot ? {ptr_ff[ADDR_BITS-1:13], 13'h0}
                             : {ptr_ff[ADDR_BITS-1:16], 16'h0};
   assign sector_last = boot ? (&ptr_ff[12:0]) : (&ptr_ff[15:0]);
   assign array_last  = &ptr_ff;

   assign idx_wide      = boot ? IW'(ptr_ff[15:13])
                               : IW'(7) + IW'(ptr_ff[ADDR_BITS-1:16]);
   assign lock_in_range = (32'(idx_wide) < 32'(NUM_SECTORS));
   assign lock_idx      = idx_wide[SW-1:0];
   assign ptr           = ptr_ff;

endmodule

/* design/fcs_array.sv */
// ----------------------------------------------------------------------------
// Flash byte array
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcs_array #(
   parameter int ADDR_BITS = fcs_pkg::ADDR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_BITS-1:0]          wr_addr,
   input  logic [fcs_pkg::BYTE_W-1:0]    wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_BITS-1:0]          rd_addr,
   output logic [fcs_pkg::BYTE_W-1:0]    rd_data
);
   import fcs_pkg::*;

   logic [BYTE_W-1:0] mem_ff [0:(1 << ADDR_BITS)-1];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/flash_command_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// Flash command sequencer unit
// Parallel flash device model: command cycle decode, byte array, sector locks.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake        payload
//   req_bus  in         valid / ready    action, address, write_byte
//   rsp_bus  out        valid / ready    read_data, read_valid, current_mode
//   csr_bus  in         valid / ready    reg_index, write_data (always ready)
//
// Each item runs to its end before the next one is accepted. A command
// write passes through the execute and done steps, a program adds a merge
// write; an array read gathers four bytes through the single array read
// port, one per cycle. A sector erase sweeps the shared address pointer
// once per byte over an 8 KB or 64 KB sector; a chip erase sweeps the whole
// array. After reset the array is filled with 0xFF by the same sweep, with
// req_bus.ready low; configuration writes are taken meanwhile.
// A finished result waits in the output register while the next item is
// taken; the sequencer stalls in its last step only if that register is full.
// ----------------------------------------------------------------------------
module flash_command_sequencer_unit #(
   parameter int ADDR_BITS   = fcs_pkg::ADDR_BITS_DEF,
   parameter int NUM_SECTORS = fcs_pkg::NUM_SECTORS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   fcs_req_if.sink        req_bus,
   fcs_rsp_if.source      rsp_bus,
   fcs_csr_if.sink        csr_bus
);
   import fcs_pkg::*;

   localparam int WIDE_W = (ADDR_BITS > ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int SW     = $clog2(NUM_SECTORS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_LAST,
      ST_PROG,
      ST_ERASE,
      ST_DONE
   } state_type;

   state_type            state_ff;
   cmd_state_type        cst_ff;
   logic [NUM_SECTORS-1:0] locks_ff;
   logic [BYTE_W-1:0]    mfg_ff;
   logic [BYTE_W-1:0]    dev_ff;

   // accepted item
   logic                 act_ff;
   logic [CMD_W-1:0]     cmd_ff;
   logic [BYTE_W-1:0]    byte_ff;
   logic                 abit1_ff;

   // result under construction and output register
   logic [WORD_W-1:0]    data_ff;
   logic                 valid_ff;
   logic [1:0]           cnt_ff;
   logic                 collect_ff;
   logic                 erase_chip_ff;
   logic                 rsp_valid_ff;
   logic [WORD_W-1:0]    rsp_data_ff;
   logic                 rsp_rvalid_ff;
   mode_type             rsp_mode_ff;

   dec_type              dec;

   logic [WIDE_W-1:0]    req_addr_wide;
   logic [ADDR_BITS-1:0] req_addr;
   logic                 ptr_load;
   logic [ADDR_BITS-1:0] ptr_load_addr;
   logic                 ptr_advance;
   logic [ADDR_BITS-1:0] ptr;
   logic [ADDR_BITS-1:0] sector_base;
   logic                 sector_last;
   logic                 array_last;
   logic [SW-1:0]        lock_idx;
   logic                 lock_in_range;
   logic                 locked;

   logic                 mem_wr_en;
   logic [BYTE_W-1:0]    mem_wr_data;
   logic                 mem_rd_en;
   logic [BYTE_W-1:0]    mem_rd_data;

   assign req_addr_wide = WIDE_W'(req_bus.address);
   assign req_addr      = req_addr_wide[ADDR_BITS-1:0];

   fcs_cmd_decode u_decode (
      .action (act_ff),
      .cmd    (cmd_ff),
      .wbyte  (byte_ff),
      .cur    (cst_ff),
      .dec    (dec)
   );

   fcs_addr_unit #(
      .ADDR_BITS   (ADDR_BITS),
      .NUM_SECTORS (NUM_SECTORS)
   ) u_addr (
      .clock         (clock),
      .reset         (reset),
      .load          (ptr_load),
      .load_addr     (ptr_load_addr),
      .advance       (ptr_advance),
      .ptr           (ptr),
      .sector_base   (sector_base),
      .sector_last   (sector_last),
      .array_last    (array_last),
      .lock_idx      (lock_idx),
      .lock_in_range (lock_in_range)
   );

   fcs_array #(
      .ADDR_BITS (ADDR_BITS)
   ) u_array (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ptr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (ptr),
      .rd_data (mem_rd_data)
   );

   // a sector without a lock bit counts as unlocked
   assign locked = lock_in_range && locks_ff[lock_idx];

   // Pointer control: load the item address on accept, the sweep start on
   // an erase, and advance through reads and sweeps.
   always_comb begin
      ptr_load      = 1'b0;
      ptr_load_addr = req_addr;
      if (state_ff == ST_IDLE && req_bus.valid) begin
         ptr_load = 1'b1;
      end else if (state_ff == ST_EXEC && dec.op == OP_ERASE_CHIP) begin
         ptr_load      = 1'b1;
         ptr_load_addr = '0;
      end else if (state_ff == ST_EXEC && dec.op == OP_ERASE_SECTOR) begin
         ptr_load      = 1'b1;
         ptr_load_addr = sector_base;
      end
   end

   assign ptr_advance = (state_ff == ST_CLEAR) || (state_ff == ST_ERASE)
                        || (state_ff == ST_READ);

   // Array access: fetch bytes for reads and for the program merge, write
   // 0xFF on sweeps and old AND new on program.
   assign mem_rd_en   = (state_ff == ST_READ)
                        || (state_ff == ST_EXEC && dec.op == OP_PROGRAM && !locked);
   assign mem_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_PROG)
                        || (state_ff == ST_ERASE && !locked);
   assign mem_wr_data = (state_ff == ST_PROG) ? (mem_rd_data & byte_ff) : BYTE_ERASED;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.read_data    = rsp_data_ff;
   assign rsp_bus.read_valid   = rsp_rvalid_ff;
   assign rsp_bus.current_mode = rsp_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cst_ff        <= CST_RESET;
         locks_ff      <= '0;
         mfg_ff        <= MANUFACTURER_RESET;
         dev_ff        <= DEVICE_RESET;
         rsp_valid_ff  <= 1'b0;
         collect_ff    <= 1'b0;
         erase_chip_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         // read data arrives in the cycle after its read request
         collect_ff <= (state_ff == ST_READ);
         if (collect_ff) begin
            data_ff <= {data_ff[WORD_W-BYTE_W-1:0], mem_rd_data};
         end

         if (csr_bus.valid) begin
            case (csr_bus.reg_index)
               REG_MANUFACTURER: mfg_ff <= csr_bus.write_data;
               REG_DEVICE:       dev_ff <= csr_bus.write_data;
               default: ;
            endcase
         end

         // drop the result once taken; a new one below wins
         if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_CLEAR: begin
               if (array_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_bus.valid) begin
                  act_ff   <= req_bus.action;
                  cmd_ff   <= req_bus.address[CMD_W:1];
                  byte_ff  <= req_bus.write_byte;
                  abit1_ff <= req_bus.address[1];
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               cst_ff   <= dec.nxt;
               valid_ff <= 1'b0;
               data_ff  <= '0;
               cnt_ff   <= '0;
               case (dec.op)
                  OP_READ_ARRAY: begin
                     valid_ff <= 1'b1;
                     state_ff <= ST_READ;
                  end
                  OP_READ_ID: begin
                     valid_ff <= 1'b1;
                     data_ff  <= {(abit1_ff ? dev_ff : mfg_ff), {(WORD_W-BYTE_W){1'b0}}};
                     state_ff <= ST_DONE;
                  end
                  OP_PROGRAM: begin
                     state_ff <= locked ? ST_DONE : ST_PROG;
                  end
                  OP_ERASE_CHIP: begin
                     erase_chip_ff <= 1'b1;
                     state_ff      <= ST_ERASE;
                  end
                  OP_ERASE_SECTOR: begin
                     erase_chip_ff <= 1'b0;
                     state_ff      <= locked ? ST_DONE : ST_ERASE;
                  end
                  OP_LOCK: begin
                     if (lock_in_range) begin
                        locks_ff[lock_idx] <= 1'b1;
                     end
                     state_ff <= ST_DONE;
                  end
                  default: begin
                     state_ff <= ST_DONE;
                  end
               endcase
            end
            ST_READ: begin
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= ST_LAST;
               end
            end
            ST_LAST: begin
               state_ff <= ST_DONE;
            end
            ST_PROG: begin
               state_ff <= ST_DONE;
            end
            ST_ERASE: begin
               if (erase_chip_ff ? array_last : sector_last) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               // hold until the output register has room
               if (!rsp_valid_ff || rsp_bus.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_data_ff   <= data_ff;
                  rsp_rvalid_ff <= valid_ff;
                  rsp_mode_ff   <= cst_ff.mode;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // A locked byte must never be merged by a program.
   a_prog_unlocked: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROG) |-> !locked)
      else $error("program write into a locked sector");

   // The fill pass runs only once after reset.
   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CLEAR) |=> (state_ff != ST_CLEAR))
      else $error("fill pass re-entered");

   // A result appears only from the final step.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside the final step");

   // In read-array mode no command sequence can fall back elsewhere.
   a_read_fallback: assert property (@(posedge clock) disable iff (reset)
      (cst_ff.mode == MODE_READ) |-> (cst_ff.fb_mode == MODE_READ))
      else $error("read mode with a non-read fallback");

   // An array read gathers exactly four bytes.
   a_four_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAST) |-> ($past(state_ff == ST_READ) && $past(cnt_ff) == 2'd3))
      else $error("array read left before four bytes");

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Flash command sequencer testbench
// Drives bus accesses into the sequencer and checks every result against a
// local model of the command state machine, byte array and sector locks.
// A short directed part covers the command sequences and their corner cases;
// random sequences with stray and broken cycles follow under idle and stall
// patterns on both channels. A chip erase runs last, over locked sectors.
// ----------------------------------------------------------------------------
module testbench;
   import fcs_pkg::*;

   localparam int unsigned ARRAY_BYTES = 1 << ADDR_BITS_DEF;
   localparam int unsigned BOOT_LIMIT  = 'h10000;
   localparam int unsigned BOOT_SPAN   = 'h2000;
   localparam int unsigned MAIN_SPAN   = 'h10000;
   localparam int          BIG_ERASE_CAP = 6;

   typedef struct packed {
      logic [WORD_W-1:0] read_data;
      logic              read_valid;
      mode_type          current_mode;
   } access_result_type;

   logic clock;
   logic reset;

   fcs_req_if req_bus ();
   fcs_rsp_if rsp_bus ();
   fcs_csr_if csr_bus ();

   flash_command_sequencer_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Local copy of the device: array, locks, command state and ID codes
   bit [BYTE_W-1:0]   flash_image [ARRAY_BYTES];
   bit                sector_locked [NUM_SECTORS_DEF];
   mode_type          seq_mode;
   cycle_type         seq_cycle;
   mode_type          seq_fb_mode;
   cycle_type         seq_fb_cycle;
   logic [BYTE_W-1:0] id_manufacturer;
   logic [BYTE_W-1:0] id_device;

   access_result_type pending_results [$];
   access_result_type oldest;
   logic [ADDR_W-1:0] hot_addresses [$];
   int                mismatch_count;
   int unsigned       accesses_sent;
   int                big_erases;
   int                req_gap_pct;
   int                rsp_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: the reset sweep and the one chip erase each cover the whole
   // array, and everything else is small next to them.
   initial begin
      #150_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Model of the device
   // ---------------------------------------------------------------------
   function automatic void clear_model();
      foreach (flash_image[i]) flash_image[i] = BYTE_ERASED;
      foreach (sector_locked[i]) sector_locked[i] = 1'b0;
      seq_mode        = MODE_READ;
      seq_cycle       = CYC_IDLE;
      seq_fb_mode     = MODE_READ;
      seq_fb_cycle    = CYC_IDLE;
      id_manufacturer = MANUFACTURER_RESET;
      id_device       = DEVICE_RESET;
   endfunction

   // Boot area: 8 KB sectors on lock bits 0..7; above it 64 KB sectors
   function automatic int unsigned lock_slot(input int unsigned a);
      return (a < BOOT_LIMIT) ? (a >> 13) : (7 + (a >> 16));
   endfunction

   function automatic bit sector_is_locked(input int unsigned a);
      int unsigned slot;
      slot = lock_slot(a);
      return (slot < NUM_SECTORS_DEF) ? sector_locked[slot] : 1'b0;
   endfunction

   function automatic void wipe_sector(input int unsigned a);
      int unsigned span;
      int unsigned base;
      span = (a < BOOT_LIMIT) ? BOOT_SPAN : MAIN_SPAN;
      base = a & ~(span - 1);
      if (base >= ARRAY_BYTES || sector_is_locked(base)) return;
      if (span > ARRAY_BYTES - base) span = ARRAY_BYTES - base;
      for (int unsigned i = 0; i < span; i++) flash_image[base + i] = BYTE_ERASED;
   endfunction

   function automatic void wipe_chip();
      int unsigned a;
      a = 0;
      while (a < ARRAY_BYTES) begin
         wipe_sector(a);
         a += (a < BOOT_LIMIT) ? BOOT_SPAN : MAIN_SPAN;
      end
   endfunction

   function automatic void back_to_read();
      seq_mode     = MODE_READ;
      seq_fb_mode  = MODE_READ;
      seq_cycle    = CYC_IDLE;
      seq_fb_cycle = CYC_IDLE;
   endfunction

   function automatic void fall_back();
      seq_mode  = seq_fb_mode;
      seq_cycle = seq_fb_cycle;
   endfunction

   // Advance the command state machine by one access and form its result
   function automatic access_result_type predict_access(input logic act,
         input logic [ADDR_W-1:0] a, input logic [BYTE_W-1:0] d);
      access_result_type r;
      logic [CMD_W-1:0]  cmd;
      int unsigned       slot;
      cmd = a[CMD_W:1];
      r = '{read_data: '0, read_valid: 1'b0, current_mode: MODE_READ};
      if (act) begin
         case (seq_mode)
            MODE_READ: begin
               if (seq_cycle == CYC_IDLE) begin
                  if (cmd[7:0] == CMD_CFI_LOW && d == BYTE_CFI) begin
                     seq_mode     = MODE_CFI;
                     seq_fb_mode  = MODE_CFI;
                     seq_cycle    = CYC_IDLE;
                     seq_fb_cycle = CYC_IDLE;
                  end else if (cmd == CMD_ADDR_A && d == BYTE_UNLOCK_A) begin
                     seq_cycle = CYC_TWO;
                  end else begin
                     fall_back();
                  end
               end else if (seq_cycle == CYC_TWO) begin
                  if (cmd == CMD_ADDR_B && d == BYTE_UNLOCK_B) seq_cycle = CYC_THREE;
                  else fall_back();
               end else if (seq_cycle == CYC_THREE) begin
                  if (cmd == CMD_ADDR_A && d == BYTE_ERASE) begin
                     seq_mode  = MODE_ERASE;
                     seq_cycle = CYC_FOUR;
                  end else if (cmd == CMD_ADDR_A && d == BYTE_PID) begin
                     seq_mode     = MODE_PID;
                     seq_fb_mode  = MODE_PID;
                     seq_cycle    = CYC_IDLE;
                     seq_fb_cycle = CYC_IDLE;
                  end else if (cmd == CMD_ADDR_A && d == BYTE_PROGRAM) begin
                     seq_mode  = MODE_PROG;
                     seq_cycle = CYC_FOUR;
                  end else begin
                     fall_back();
                  end
               end
            end
            MODE_CFI, MODE_PID: begin
               if (d == BYTE_EXIT) back_to_read();
            end
            MODE_PROG: begin
               if (!sector_is_locked(a)) flash_image[a] = flash_image[a] & d;
               back_to_read();
            end
            MODE_ERASE: begin
               if (seq_cycle == CYC_FOUR) begin
                  if (cmd == CMD_ADDR_A && d == BYTE_UNLOCK_A) seq_cycle = CYC_FIVE;
                  else fall_back();
               end else if (seq_cycle == CYC_FIVE) begin
                  if (cmd == CMD_ADDR_B && d == BYTE_UNLOCK_B) seq_cycle = CYC_SIX;
                  else fall_back();
               end else if (seq_cycle == CYC_SIX) begin
                  // any other byte leaves the device waiting at this cycle
                  if (d == BYTE_CHIP) begin
                     if (cmd == CMD_ADDR_A) wipe_chip();
                     back_to_read();
                  end else if (d == BYTE_SECTOR) begin
                     wipe_sector(a);
                     back_to_read();
                  end else if (d == BYTE_LOCK) begin
                     slot = lock_slot(a);
                     if (slot < NUM_SECTORS_DEF) sector_locked[slot] = 1'b1;
                     back_to_read();
                  end
               end
            end
            default: ;
         endcase
      end else if (seq_mode == MODE_READ) begin
         r.read_data = {flash_image[a], flash_image[ADDR_W'(a + 1)],
                        flash_image[ADDR_W'(a + 2)], flash_image[ADDR_W'(a + 3)]};
         r.read_valid = 1'b1;
      end else if (seq_mode == MODE_PID) begin
         r.read_data  = {(a[1] ? id_device : id_manufacturer), 24'h0};
         r.read_valid = 1'b1;
      end
      r.current_mode = seq_mode;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: compare each accepted result with the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with no access waiting: data %h valid %b mode %0d",
                     $time, rsp_bus.read_data, rsp_bus.read_valid, rsp_bus.current_mode);
            mismatch_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_bus.read_data !== oldest.read_data) begin
               $display("%0t: read_data expected %h actual %h",
                        $time, oldest.read_data, rsp_bus.read_data);
               mismatch_count++;
            end
            if (rsp_bus.read_valid !== oldest.read_valid) begin
               $display("%0t: read_valid expected %b actual %b",
                        $time, oldest.read_valid, rsp_bus.read_valid);
               mismatch_count++;
            end
            if (rsp_bus.current_mode !== oldest.current_mode) begin
               $display("%0t: current_mode expected %0d actual %0d",
                        $time, oldest.current_mode, rsp_bus.current_mode);
               mismatch_count++;
            end
         end
      end
   end

   // Receiver: stall at the rate of the current phase, change at falling edge
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Item drivers
   // ---------------------------------------------------------------------
   // Starts and ends at a falling edge; valid stays high after an item so
   // that back-to-back items never drop and raise it in one step.
   task automatic send_access(input logic act, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] wb);
      while ($urandom_range(99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.address    <= addr;
      req_bus.write_byte <= wb;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_results.push_back(predict_access(act, addr, wb));
      accesses_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold until every predicted result has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_id_codes(input logic [BYTE_W-1:0] manufacturer,
                                 input logic [BYTE_W-1:0] device);
      wait_drained();
      csr_bus.valid      <= 1'b1;
      csr_bus.reg_index  <= REG_MANUFACTURER;
      csr_bus.write_data <= manufacturer;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      id_manufacturer = manufacturer;
      @(negedge clock);
      csr_bus.reg_index  <= REG_DEVICE;
      csr_bus.write_data <= device;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      id_device = device;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Command address sits in bits 11..1; scramble the bits around it
   function automatic logic [ADDR_W-1:0] cmd_address(input logic [CMD_W-1:0] cmd);
      logic [ADDR_W-CMD_W-2:0] upper;
      logic                    lowest;
      upper  = (ADDR_W-CMD_W-1)'($urandom);
      lowest = 1'($urandom);
      return {upper, cmd, lowest};
   endfunction

   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] wb);
      send_access(1'b1, cmd_address(cmd), wb);
   endtask

   task automatic send_read(input logic [ADDR_W-1:0] addr);
      send_access(1'b0, addr, BYTE_W'($urandom));
   endtask

   task automatic issue_unlock(input logic [BYTE_W-1:0] third);
      send_command(CMD_ADDR_A, BYTE_UNLOCK_A);
      send_command(CMD_ADDR_B, BYTE_UNLOCK_B);
      send_command(CMD_ADDR_A, third);
   endtask

   function automatic void remember_address(input logic [ADDR_W-1:0] a);
      hot_addresses.push_back(a);
      if (hot_addresses.size() > 24) void'(hot_addresses.pop_front());
   endfunction

   function automatic logic [ADDR_W-1:0] pool_address();
      return hot_addresses[$urandom_range(hot_addresses.size() - 1)];
   endfunction

   // Bias toward written bytes, sector edges and the wraparound at the top
   function automatic logic [ADDR_W-1:0] pick_address();
      int               r;
      logic [ADDR_W-1:0] a;
      r = $urandom_range(99);
      a = ADDR_W'($urandom);
      if (r < 40 && hot_addresses.size() != 0) begin
         a = pool_address() - ADDR_W'($urandom_range(3));
      end else if (r < 60) begin
         case ($urandom_range(5))
            0: a = 20'hFFFFC + ADDR_W'($urandom_range(3));
            1: a = 20'h00000;
            2: a = 20'h01FFE;
            3: a = 20'h0FFFE;
            4: a = 20'h1FFFE;
            default: a = 20'hEFFFD;
         endcase
      end
      return a;
   endfunction

   function automatic logic [BYTE_W-1:0] pick_command_byte();
      case ($urandom_range(9))
         0: return BYTE_UNLOCK_A;
         1: return BYTE_UNLOCK_B;
         2: return BYTE_CFI;
         3: return BYTE_ERASE;
         4: return BYTE_PID;
         5: return BYTE_PROGRAM;
         6: return BYTE_EXIT;
         7: return BYTE_LOCK;
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   // Stray write from whatever state the device is in. Erase commands at the
   // last erase cycle are turned into an ignored byte to keep the run short.
   task automatic send_stray_write();
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] wb;
      addr = ADDR_W'($urandom);
      wb   = $urandom_range(1) ? pick_command_byte() : BYTE_W'($urandom);
      if ($urandom_range(2) == 0)
         addr = cmd_address($urandom_range(1) ? CMD_ADDR_A : CMD_ADDR_B);
      if (seq_mode == MODE_ERASE && seq_cycle == CYC_SIX &&
          (wb == BYTE_CHIP || wb == BYTE_SECTOR))
         wb = 8'h00;
      send_access(1'b1, addr, wb);
   endtask

   // Walk the device back to the idle read state with the cheapest writes
   task automatic bring_to_read_idle();
      while (!(seq_mode == MODE_READ && seq_cycle == CYC_IDLE)) begin
         case (seq_mode)
            MODE_CFI, MODE_PID: send_command(CMD_W'($urandom), BYTE_EXIT);
            MODE_PROG: send_access(1'b1, pick_address(), BYTE_W'($urandom));
            MODE_ERASE: begin
               if (seq_cycle == CYC_SIX) send_command(CMD_ADDR_B, BYTE_CHIP);
               else send_command('0, 8'h00);
            end
            default: send_command('0, 8'h00);
         endcase
      end
   endtask

   task automatic program_byte(input logic [ADDR_W-1:0] target, input logic [BYTE_W-1:0] wb);
      bring_to_read_idle();
      issue_unlock(BYTE_PROGRAM);
      if ($urandom_range(4) == 0) send_read(pick_address());
      send_access(1'b1, target, wb);
      remember_address(target);
   endtask

   // Erase-family command sequence; its last cycle carries addr and final_byte
   task automatic erase_command(input logic [ADDR_W-1:0] addr,
                                input logic [BYTE_W-1:0] final_byte);
      logic [BYTE_W-1:0] stray;
      bring_to_read_idle();
      issue_unlock(BYTE_ERASE);
      if ($urandom_range(3) == 0) send_read(pick_address());
      send_command(CMD_ADDR_A, BYTE_UNLOCK_A);
      send_command(CMD_ADDR_B, BYTE_UNLOCK_B);
      if ($urandom_range(3) == 0) begin
         stray = BYTE_W'($urandom);
         if (stray == BYTE_CHIP || stray == BYTE_SECTOR || stray == BYTE_LOCK) stray = 8'h00;
         send_command(CMD_W'($urandom), stray);
      end
      send_access(1'b1, addr, final_byte);
   endtask

   task automatic visit_product_id();
      logic [BYTE_W-1:0] stray;
      bring_to_read_idle();
      issue_unlock(BYTE_PID);
      repeat ($urandom_range(1, 3)) send_read(ADDR_W'($urandom));
      if ($urandom_range(1)) begin
         stray = BYTE_W'($urandom);
         if (stray == BYTE_EXIT) stray = 8'h00;
         send_command(CMD_W'($urandom), stray);
      end
      send_command(CMD_W'($urandom), BYTE_EXIT);
   endtask

   task automatic visit_cfi();
      logic [CMD_W-1:0]  cmd;
      logic [BYTE_W-1:0] stray;
      bring_to_read_idle();
      cmd      = CMD_W'($urandom);
      cmd[7:0] = CMD_CFI_LOW;
      send_command(cmd, BYTE_CFI);
      send_read(ADDR_W'($urandom));
      if ($urandom_range(1)) begin
         stray = pick_command_byte();
         if (stray == BYTE_EXIT) stray = 8'h00;
         send_command(CMD_W'($urandom), stray);
      end
      send_command(CMD_W'($urandom), BYTE_EXIT);
   endtask

   // Part of an erase sequence, then a cycle that does not belong
   task automatic send_broken_sequence();
      logic [CMD_W-1:0]  steps_cmd  [5];
      logic [BYTE_W-1:0] steps_byte [5];
      int                depth;
      steps_cmd  = '{CMD_ADDR_A, CMD_ADDR_B, CMD_ADDR_A, CMD_ADDR_A, CMD_ADDR_B};
      steps_byte = '{BYTE_UNLOCK_A, BYTE_UNLOCK_B, BYTE_ERASE, BYTE_UNLOCK_A, BYTE_UNLOCK_B};
      depth = $urandom_range(1, 5);
      bring_to_read_idle();
      for (int i = 0; i < depth; i++) send_command(steps_cmd[i], steps_byte[i]);
      send_stray_write();
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_erased_array_read();
      // read across the top of the array: wraps to address zero
      send_read(20'hFFFFE);
   endtask

   task automatic test_cfi_mode();
      // CFI entry mid-sequence is a wrong cycle, not an entry
      send_command(CMD_ADDR_A, BYTE_UNLOCK_A);
      send_command({3'b101, CMD_CFI_LOW}, BYTE_CFI);
      send_command({3'b111, CMD_CFI_LOW}, BYTE_CFI);
      send_read(20'h00000);
      send_command(CMD_ADDR_A, 8'hFF);
      send_command('0, BYTE_EXIT);
   endtask

   task automatic test_product_id();
      issue_unlock(BYTE_PID);
      send_read(20'h00000);
      send_read(20'hFFFFF);
      send_command(CMD_ADDR_B, 8'h00);
      // swap the ID codes to the opposite extremes while parked in ID mode
      write_id_codes(8'hFF, 8'h00);
      send_read(20'h00002);
      send_read(20'hFFFFD);
      send_command(CMD_ADDR_A, BYTE_EXIT);
   endtask

   task automatic test_program_byte();
      issue_unlock(BYTE_PROGRAM);
      send_read(20'h12345);
      send_access(1'b1, 20'hFFFFF, 8'h5A);
      remember_address(20'hFFFFF);
      send_read(20'hFFFFE);
   endtask

   task automatic test_erase_cycle_six();
      issue_unlock(BYTE_ERASE);
      send_read(20'hFFFFE);
      send_command(CMD_ADDR_A, BYTE_UNLOCK_A);
      send_command(CMD_ADDR_B, BYTE_UNLOCK_B);
      // unknown byte: hold at cycle six
      send_command(CMD_ADDR_A, 8'h00);
      // chip erase byte off the command address: erase nothing, back to read
      send_command(CMD_ADDR_B, BYTE_CHIP);
      send_read(20'hFFFFE);
   endtask

   task automatic test_random_sequences(input int count);
      int unsigned       first;
      int                pick;
      logic [ADDR_W-1:0] target;
      logic [CMD_W-1:0]  cmd;
      first = accesses_sent;
      while (accesses_sent - first < count) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            send_read(pick_address());
         end else if (pick < 55) begin
            target = ($urandom_range(1) && hot_addresses.size() != 0) ? pool_address()
                                                                      : pick_address();
            program_byte(target, BYTE_W'($urandom));
         end else if (pick < 62) begin
            visit_product_id();
         end else if (pick < 67) begin
            visit_cfi();
         end else if (pick < 72) begin
            // mostly boot sectors; big sectors are slow, so cap them
            target = ADDR_W'($urandom_range(BOOT_LIMIT - 1));
            if ($urandom_range(1) && hot_addresses.size() != 0) target = pool_address();
            if (target >= BOOT_LIMIT && big_erases >= BIG_ERASE_CAP) target[19:16] = '0;
            if (target >= BOOT_LIMIT) big_erases++;
            erase_command(target, BYTE_SECTOR);
         end else if (pick < 74) begin
            erase_command(ADDR_W'($urandom), BYTE_LOCK);
         end else if (pick < 77) begin
            cmd = CMD_W'($urandom);
            if (cmd == CMD_ADDR_A) cmd = CMD_ADDR_B;
            erase_command(cmd_address(cmd), BYTE_CHIP);
         end else if (pick < 87) begin
            send_broken_sequence();
         end else if ($urandom_range(1)) begin
            send_read(ADDR_W'($urandom));
         end else begin
            send_stray_write();
         end
      end
   endtask

   task automatic test_chip_erase();
      // lock the top sector so its programmed byte survives the erase
      erase_command(20'hF0123, BYTE_LOCK);
      erase_command(cmd_address(CMD_ADDR_A), BYTE_CHIP);
      send_read(20'hFFFFE);
      repeat (4) send_read(pick_address());
   endtask

   // ---------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------
   initial begin
      int gap_plan   [4];
      int stall_plan [4];
      gap_plan   = '{0, 59, 0, 9};
      stall_plan = '{0, 0, 59, 9};

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = 1'b0;
      req_bus.address    = '0;
      req_bus.write_byte = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.reg_index  = REG_MANUFACTURER;
      csr_bus.write_data = '0;
      req_gap_pct        = 0;
      rsp_stall_pct      = 0;
      mismatch_count     = 0;
      accesses_sent      = 0;
      big_erases         = 0;
      clear_model();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ID codes go in while the array clears; start from the extremes
      write_id_codes(8'h00, 8'hFF);

      test_erased_array_read();
      test_cfi_mode();
      test_product_id();
      test_program_byte();
      test_erase_cycle_six();

      // Random part in four idle/stall phases, new ID codes for each
      for (int phase = 0; phase < 4; phase++) begin
         write_id_codes(BYTE_W'($urandom), BYTE_W'($urandom));
         req_gap_pct   = gap_plan[phase];
         rsp_stall_pct = stall_plan[phase];
         test_random_sequences(287);
      end

      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      test_chip_erase();

      // Drain, then allow a margin for any stray result
      wait_drained();
      repeat (64) @(negedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
design/fcs_pkg.sv
design/fcs_req_if.sv
design/fcs_rsp_if.sv
design/fcs_csr_if.sv
design/fcs_cmd_decode.sv
design/fcs_addr_unit.sv
design/fcs_array.sv
design/flash_command_sequencer_unit.sv
tb/testbench.sv
